FILE: hdl/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and codes for the periodic priority task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

  // default table depth
  localparam int MAX_TASKS_DEF = 16;

  // field widths
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int TIME_W   = 16;
  localparam int MODE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 32;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

  // one task table entry
  typedef struct packed {
    logic [TIME_W-1:0] countdown;
    logic [TIME_W-1:0] period;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

FILE: hdl/periodic_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler
// Priority ordered table of periodic tasks with add, remove and timer tick.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                              content
//  s_axis    in         tvalid tready tdata[47:0] tuser[1:0] request, tuser = mode
//  m_axis    out        tvalid tready tdata[31:0] tuser[1:0] tlast  result, tuser = kind
//  cfg       in         valid ready data[15:0]               tick_divider write
//
//  A request is taken only while the sequencer is idle; the table lives in a
//  single-port-write memory with a registered read, walked one entry at a time
//  by one shared decrement/compare unit.
//  Each result waits on m_axis_tready, and a scheduler tick walk holds while
//  a second fired id waits for a free output register.
//  A raw tick with no scheduler tick, or mode three, returns to idle with no result.
//  rst (synchronous) empties the table and clears the prescaler and tick count.
//  s_axis and cfg are not ready while rst is high; cfg is ready otherwise.
//
module periodic_priority_task_scheduler #(
  parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // task_id[7:0], priority_req[15:8], period[31:16], initial_remaining[47:32]
  input  logic [ppts_pkg::IN_DW-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [ppts_pkg::MODE_W-1:0]  s_axis_tuser,
  // result
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // ok[0], id[8:1], os_tick[24:9], zero[31:25]
  output logic [ppts_pkg::OUT_DW-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [ppts_pkg::KIND_W-1:0]  m_axis_tuser,
  output logic                         m_axis_tlast,
  // tick_divider write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ppts_pkg::TIME_W-1:0]  cfg_data
);
  import ppts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EMIT   = 3'd1;
  localparam logic [2:0] S_ADD_RD = 3'd2;
  localparam logic [2:0] S_ADD_WR = 3'd3;
  localparam logic [2:0] S_REM_RD = 3'd4;
  localparam logic [2:0] S_REM_WR = 3'd5;
  localparam logic [2:0] S_TK_RD  = 3'd6;
  localparam logic [2:0] S_TK_WR  = 3'd7;

  logic [2:0]        state;
  logic [CNT_W-1:0]  task_count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  wr_idx;
  logic              hit;
  logic [TIME_W-1:0] prescale_count;
  logic [TIME_W-1:0] sched_ticks;
  logic [TIME_W-1:0] tick_divider;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;

  // latched request
  logic [MODE_W-1:0] req_mode;
  logic [ID_W-1:0]   req_id;
  logic [PRIO_W-1:0] req_prio;
  logic [TIME_W-1:0] req_period;
  logic [TIME_W-1:0] req_rem;
  logic              req_ok;

  // result register
  logic [KIND_W-1:0] out_kind;
  logic              out_ok;
  logic [ID_W-1:0]   out_id;
  logic [TIME_W-1:0] out_os;
  logic              out_last;

  // task table memory
  entry_t            table_mem [MAX_TASKS];
  entry_t            rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  entry_t            new_entry;
  logic              out_free;
  logic              pend_free;
  logic [TIME_W-1:0] alu_in;
  logic [TIME_W-1:0] alu_dec;
  logic              fire;
  logic [TIME_W-1:0] pre_inc;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign cfg_ready     = !rst;
  assign m_axis_tdata  = {{(OUT_DW-TIME_W-ID_W-1){1'b0}}, out_os, out_id, out_ok};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign pend_free = !pend_valid || out_free;
  assign pre_inc   = prescale_count + TIME_W'(1);

  assign new_entry = '{countdown: req_rem, period: req_period, prio: req_prio, id: req_id};

  // shared decrement unit: reload from period on fire, then count down
  assign fire    = (rd_data.countdown == '0);
  assign alu_in  = fire ? rd_data.period : rd_data.countdown;
  assign alu_dec = alu_in - TIME_W'(1);

  // read address
  always_comb begin
    if (state == S_ADD_RD) begin
      rd_addr = idx[IDX_W-1:0] - IDX_W'(1);
    end else begin
      rd_addr = idx[IDX_W-1:0];
    end
  end

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[IDX_W-1:0];
    mem_wdata = rd_data;
    case (state)
      S_ADD_RD: begin
        mem_we    = (idx == '0);
        mem_wdata = new_entry;
      end
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_data.prio > req_prio) ? rd_data : new_entry;
      end
      S_REM_WR: begin
        mem_we    = (rd_data.id != req_id);
        mem_waddr = wr_idx[IDX_W-1:0];
      end
      S_TK_WR: begin
        mem_we              = !fire || pend_free;
        mem_wdata.countdown = alu_dec;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      task_count     <= '0;
      prescale_count <= '0;
      sched_ticks    <= '0;
      tick_divider   <= TIME_W'(1);
      m_axis_tvalid  <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_divider <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        // take a request and dispatch on its mode
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_mode   <= s_axis_tuser;
            req_id     <= s_axis_tdata[7:0];
            req_prio   <= s_axis_tdata[15:8];
            req_period <= s_axis_tdata[31:16];
            req_rem    <= s_axis_tdata[47:32];
            idx        <= '0;
            wr_idx     <= '0;
            hit        <= 1'b0;
            case (s_axis_tuser)
              MODE_ADD: begin
                if (task_count == CNT_W'(MAX_TASKS)) begin
                  req_ok <= 1'b0;
                  state  <= S_EMIT;
                end else begin
                  idx   <= task_count;
                  state <= S_ADD_RD;
                end
              end
              MODE_REMOVE: begin
                state <= S_REM_RD;
              end
              MODE_TICK: begin
                if (pre_inc < tick_divider) begin
                  prescale_count <= pre_inc;
                end else begin
                  prescale_count <= '0;
                  sched_ticks    <= sched_ticks + TIME_W'(1);
                  state          <= S_TK_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // status result of an add or a remove
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_kind      <= (req_mode == MODE_ADD) ? KIND_ADD : KIND_REMOVE;
            out_ok        <= req_ok;
            out_id        <= req_id;
            out_os        <= sched_ticks;
            out_last      <= 1'b1;
            state         <= S_IDLE;
          end
        end

        // insertion: move larger priorities up one place from the top
        S_ADD_RD: begin
          if (idx == '0) begin
            task_count <= task_count + CNT_W'(1);
            req_ok     <= 1'b1;
            state      <= S_EMIT;
          end else begin
            state <= S_ADD_WR;
          end
        end

        S_ADD_WR: begin
          if (rd_data.prio > req_prio) begin
            idx   <= idx - CNT_W'(1);
            state <= S_ADD_RD;
          end else begin
            task_count <= task_count + CNT_W'(1);
            req_ok     <= 1'b1;
            state      <= S_EMIT;
          end
        end

        // removal: compact surviving entries toward the front
        S_REM_RD: begin
          if (idx == task_count) begin
            task_count <= wr_idx;
            req_ok     <= hit;
            state      <= S_EMIT;
          end else begin
            state <= S_REM_WR;
          end
        end

        S_REM_WR: begin
          if (rd_data.id == req_id) begin
            hit <= 1'b1;
          end else begin
            wr_idx <= wr_idx + CNT_W'(1);
          end
          idx   <= idx + CNT_W'(1);
          state <= S_REM_RD;
        end

        // scheduler tick: walk the table, hold back one fired id for tlast
        S_TK_RD: begin
          if (idx == task_count) begin
            if (!pend_valid) begin
              state <= S_IDLE;
            end else if (out_free) begin
              m_axis_tvalid <= 1'b1;
              out_kind      <= KIND_FIRED;
              out_ok        <= 1'b1;
              out_id        <= pend_id;
              out_os        <= sched_ticks;
              out_last      <= 1'b1;
              pend_valid    <= 1'b0;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_TK_WR;
          end
        end

        S_TK_WR: begin
          if (!fire) begin
            idx   <= idx + CNT_W'(1);
            state <= S_TK_RD;
          end else if (pend_free) begin
            if (pend_valid) begin
              m_axis_tvalid <= 1'b1;
              out_kind      <= KIND_FIRED;
              out_ok        <= 1'b1;
              out_id        <= pend_id;
              out_os        <= sched_ticks;
              out_last      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_id    <= rd_data.id;
            idx        <= idx + CNT_W'(1);
            state      <= S_TK_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/periodic_priority_task_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler_test
// Self-checking bench for the periodic priority task scheduler. A directed
// table covers reset state, field extremes, table full, removes with and
// without a match, period zero and the unused mode. Random requests follow
// over several divider settings and idling phases. A behavioral task table
// predicts every result not fixed by a directed row, compared field by field.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_test;
  import ppts_pkg::*;

  localparam int MAX_TASKS     = MAX_TASKS_DEF;
  localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
  } sched_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] os_tick;
    logic              last;
  } sched_res_t;

  // one directed step: fixed_count < 0 means use the predicted results
  typedef struct {
    sched_req_t req;
    int         fixed_count;
    sched_res_t fixed_res;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata = '0;
  logic [MODE_W-1:0]   s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic [KIND_W-1:0]   m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TIME_W-1:0]   cfg_data = '0;

  // task table copy and timer state
  entry_t            task_tbl [MAX_TASKS];
  int                n_tasks = 0;
  logic [TIME_W-1:0] prescale = '0;
  logic [TIME_W-1:0] os_ticks = '0;
  logic [TIME_W-1:0] divider = 16'd1;

  sched_res_t pending_results [$];
  sched_res_t step_results [$];
  script_row_t script [$];
  int error_count = 0;

  // idling controls
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_kick = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  always #10 clk = ~clk;

  periodic_priority_task_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic sched_res_t make_result(input logic [KIND_W-1:0] kind, input logic ok,
                                             input logic [ID_W-1:0] id, input logic last);
    sched_res_t res;
    res.kind    = kind;
    res.ok      = ok;
    res.id      = id;
    res.os_tick = os_ticks;
    res.last    = last;
    return res;
  endfunction

  // apply one request to the table copy, results land in step_results
  task automatic schedule_step(input sched_req_t req);
    int         pos;
    int         k;
    int         wr;
    logic       hit;
    sched_res_t res;
    step_results.delete();
    case (req.mode)
      MODE_ADD: begin
        hit = 1'b0;
        if (n_tasks < MAX_TASKS) begin
          pos = 0;
          while (pos < n_tasks && task_tbl[pos].prio <= req.prio) pos++;
          for (k = n_tasks; k > pos; k--) task_tbl[k] = task_tbl[k-1];
          task_tbl[pos].id        = req.id;
          task_tbl[pos].prio      = req.prio;
          task_tbl[pos].period    = req.period;
          task_tbl[pos].countdown = req.remaining;
          n_tasks++;
          hit = 1'b1;
        end
        step_results.push_back(make_result(KIND_ADD, hit, req.id, 1'b1));
      end
      MODE_REMOVE: begin
        wr  = 0;
        hit = 1'b0;
        for (k = 0; k < n_tasks; k++) begin
          if (task_tbl[k].id == req.id) begin
            hit = 1'b1;
          end else begin
            task_tbl[wr] = task_tbl[k];
            wr++;
          end
        end
        n_tasks = wr;
        step_results.push_back(make_result(KIND_REMOVE, hit, req.id, 1'b1));
      end
      MODE_TICK: begin
        prescale = prescale + 16'd1;
        if (prescale >= divider) begin
          prescale = '0;
          os_ticks = os_ticks + 16'd1;
          // walk in priority order, fire on zero then count down
          for (k = 0; k < n_tasks; k++) begin
            if (task_tbl[k].countdown == '0) begin
              task_tbl[k].countdown = task_tbl[k].period;
              step_results.push_back(make_result(KIND_FIRED, 1'b1, task_tbl[k].id, 1'b0));
            end
            task_tbl[k].countdown = task_tbl[k].countdown - 16'd1;
          end
          if (step_results.size() != 0) begin
            res = step_results.pop_back();
            res.last = 1'b1;
            step_results.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic script_row_t step_row(input logic [MODE_W-1:0] mode,
                                           input logic [ID_W-1:0] id,
                                           input logic [PRIO_W-1:0] prio,
                                           input logic [TIME_W-1:0] period,
                                           input logic [TIME_W-1:0] remaining,
                                           input int fixed_count, input logic ok,
                                           input logic [TIME_W-1:0] os_tick);
    script_row_t row;
    row.req.mode          = mode;
    row.req.id            = id;
    row.req.prio          = prio;
    row.req.period        = period;
    row.req.remaining     = remaining;
    row.fixed_count       = fixed_count;
    row.fixed_res.kind    = (mode == MODE_REMOVE) ? KIND_REMOVE : KIND_ADD;
    row.fixed_res.ok      = ok;
    row.fixed_res.id      = id;
    row.fixed_res.os_tick = os_tick;
    row.fixed_res.last    = 1'b1;
    return row;
  endfunction

  // random request: mostly small ids, priorities and countdowns so tasks fire
  function automatic sched_req_t random_request();
    sched_req_t req;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 48) req.mode = MODE_TICK;
    else if (pick < 78) req.mode = MODE_ADD;
    else if (pick < 97) req.mode = MODE_REMOVE;
    else req.mode = MODE_UNUSED;
    req.id = ($urandom_range(4) == 0) ? ID_W'($urandom_range(255)) : ID_W'($urandom_range(15));
    if (req.mode == MODE_REMOVE && n_tasks != 0 && $urandom_range(9) < 7)
      req.id = task_tbl[$urandom_range(n_tasks - 1)].id;
    req.prio      = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(254)) :
                                               PRIO_W'($urandom_range(7));
    req.period    = ($urandom_range(5) == 0) ? TIME_W'($urandom_range(65535)) :
                                               TIME_W'($urandom_range(6));
    req.remaining = ($urandom_range(5) == 0) ? TIME_W'($urandom_range(65535)) :
                                               TIME_W'($urandom_range(6));
    return req;
  endfunction

  // offer one request, then log what it should produce
  task automatic send_request(input sched_req_t req, input int fixed_count,
                              input sched_res_t fixed_res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.remaining, req.period, req.prio, req.id};
    s_axis_tuser  <= req.mode;
    do @(posedge clk); while (!s_axis_tready);
    schedule_step(req);
    if (fixed_count < 0) begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end else if (fixed_count == 1) begin
      pending_results.push_back(fixed_res);
    end
  endtask

  // let the block drain before touching the divider
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divider(input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    divider = value;
  endtask

  task automatic flag_error(input string what, input sched_res_t want, input sched_res_t got);
    error_count++;
    if (error_count <= 10) begin
      $write("%0t %s: expected kind=%0d ok=%0d id=%02h os_tick=%0d last=%0d, ",
             $time, what, want.kind, want.ok, want.id, want.os_tick, want.last);
      $display("got kind=%0d ok=%0d id=%02h os_tick=%0d last=%0d",
               got.kind, got.ok, got.id, got.os_tick, got.last);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_kick != hold_ack) begin
      hold_ack      <= hold_kick;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    sched_res_t got;
    sched_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.ok      = m_axis_tdata[0];
      got.id      = m_axis_tdata[8:1];
      got.os_tick = m_axis_tdata[24:9];
      got.last    = m_axis_tlast;
      if (pending_results.size() == 0) begin
        flag_error("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) flag_error("result mismatch", want, got);
        else if (m_axis_tdata[31:25] != '0) flag_error("nonzero padding", want, got);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int         k;
    int         phase;
    int         phase_idle [4]  = '{0, 82, 0, 29};
    int         phase_stall [4] = '{0, 0, 82, 29};
    int         phase_div [4]   = '{1, 0, 2, 3};
    sched_req_t req;
    sched_res_t none;
    none = '0;

    // directed table, divider at its reset value
    script.push_back(step_row(MODE_TICK,   8'h00, 8'd0,   16'd0,     16'd0,     0, 1'b0, 16'd0));
    script.push_back(step_row(MODE_REMOVE, 8'h55, 8'd0,   16'd0,     16'd0,     1, 1'b0, 16'd1));
    script.push_back(step_row(MODE_ADD,    8'h00, 8'd0,   16'd1,     16'd0,     1, 1'b1, 16'd1));
    script.push_back(step_row(MODE_ADD,    8'hFF, 8'd254, 16'd65535, 16'd65535, 1, 1'b1, 16'd1));
    // period zero, same priority as the previous entry
    script.push_back(step_row(MODE_ADD,    8'hA5, 8'd254, 16'd0,     16'd1,    -1, 1'b0, 16'd0));
    // duplicate ids
    script.push_back(step_row(MODE_ADD,    8'h5A, 8'h80,  16'd2,     16'd0,    -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_ADD,    8'h5A, 8'h80,  16'd3,     16'd2,    -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_TICK,   8'h00, 8'd0,   16'd0,     16'd0,    -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_TICK,   8'h00, 8'd0,   16'd0,     16'd0,    -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_UNUSED, 8'hFF, 8'd254, 16'hFFFF,  16'hFFFF,  0, 1'b0, 16'd0));
    // fill the table
    for (k = 0; k < 11; k++)
      script.push_back(step_row(MODE_ADD, ID_W'(16 + k), PRIO_W'((k * 37) % 255),
                                TIME_W'(k + 1), (k % 3 == 0) ? 16'd3 : 16'd0,
                                -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_ADD,    8'h77, 8'd3,   16'd5,     16'd0,     1, 1'b0, 16'd3));
    script.push_back(step_row(MODE_TICK,   8'h00, 8'd0,   16'd0,     16'd0,    -1, 1'b0, 16'd0));
    script.push_back(step_row(MODE_REMOVE, 8'h5A, 8'd0,   16'd0,     16'd0,    -1, 1'b0, 16'd0));

    // reset
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_request(script[i].req, script[i].fixed_count, script[i].fixed_res);

    // largest divider, then lowered below the prescaler
    settle();
    write_divider(16'hFFFF);
    req = '0;
    req.mode = MODE_TICK;
    repeat (5) send_request(req, -1, none);
    settle();
    write_divider(16'd2);
    send_request(req, -1, none);

    // random phases
    for (phase = 0; phase < 4; phase++) begin
      settle();
      write_divider(TIME_W'(phase_div[phase]));
      send_idle_pct = phase_idle[phase];
      stall_pct     = phase_stall[phase];
      if (phase == 0) hold_kick <= ~hold_kick;
      for (k = 0; k < PHASE_ITEMS; k++) send_request(random_request(), -1, none);
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("results never seen: %0d", pending_results.size());
    end
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
